/* sv/bvrc_pkg.sv */
package bvrc_pkg;

  localparam int CB  = 16;
  localparam int EW  = CB - 1;
  // Quotient bits resolved in each divider stage.
  localparam int BPS = 4;
  localparam int PW  = 2 * CB + 1;
  localparam int NST = (PW + BPS - 1) / BPS;
  localparam int QPW = NST * BPS;
  localparam int MW  = QPW + 2;

  localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
  localparam logic [2:0] REG_CLIP_TOP    = 3'd1;
  localparam logic [2:0] REG_CLIP_RIGHT  = 3'd2;
  localparam logic [2:0] REG_CLIP_BOTTOM = 3'd3;
  localparam logic [2:0] REG_EXT_WIDTH   = 3'd4;
  localparam logic [2:0] REG_EXT_HEIGHT  = 3'd5;

  typedef logic signed [CB-1:0] crd_t;

  typedef struct packed {
    logic signed [CB-1:0] dst_x;
    logic signed [CB-1:0] dst_y;
    logic signed [CB-1:0] dst_width;
    logic signed [CB-1:0] dst_height;
    logic signed [CB-1:0] src_x;
    logic signed [CB-1:0] src_y;
    logic signed [CB-1:0] src_width;
    logic signed [CB-1:0] src_height;
    logic                 has_source;
  } req_t;

  typedef struct packed {
    logic                 visible;
    logic signed [CB-1:0] src_left;
    logic signed [CB-1:0] src_top;
    logic signed [CB-1:0] src_right;
    logic signed [CB-1:0] src_bottom;
    logic signed [CB-1:0] dst_left;
    logic signed [CB-1:0] dst_top;
    logic signed [CB-1:0] dst_right;
    logic signed [CB-1:0] dst_bottom;
  } res_t;

  typedef struct packed {
    logic signed [CB-1:0] l;
    logic signed [CB-1:0] t;
    logic signed [CB-1:0] r;
    logic signed [CB-1:0] b;
  } box_t;

  typedef struct packed {
    logic signed [MW-1:0] l;
    logic signed [MW-1:0] t;
    logic signed [MW-1:0] r;
    logic signed [MW-1:0] b;
  } mbox_t;

  typedef struct packed {
    logic  ok;
    mbox_t b;
  } hit_t;

  typedef struct packed {
    req_t  rq;
    logic  okd;
    logic  oks;
    logic  eq;
    box_t  dv;
    box_t  sv;
    mbox_t shb;
  } side1_t;

  typedef struct packed {
    req_t rq;
    logic okd;
    logic oks;
    logic eq;
    logic ok_eq;
    logic ok3;
    box_t req_box;
    box_t dv2;
    box_t sv;
  } side2_t;

  function automatic mbox_t widen(box_t a);
    mbox_t m;
    m.l = MW'(a.l);
    m.t = MW'(a.t);
    m.r = MW'(a.r);
    m.b = MW'(a.b);
    return m;
  endfunction

  function automatic box_t narrow(mbox_t a);
    box_t n;
    n.l = a.l[CB-1:0];
    n.t = a.t[CB-1:0];
    n.r = a.r[CB-1:0];
    n.b = a.b[CB-1:0];
    return n;
  endfunction

  function automatic logic box_empty(mbox_t a);
    return (a.l >= a.r) || (a.t >= a.b);
  endfunction

  function automatic hit_t box_and(mbox_t a, mbox_t b);
    hit_t h;
    h.b.l = (a.l > b.l) ? a.l : b.l;
    h.b.t = (a.t > b.t) ? a.t : b.t;
    h.b.r = (a.r < b.r) ? a.r : b.r;
    h.b.b = (a.b < b.b) ? a.b : b.b;
    h.ok  = !box_empty(a) && !box_empty(b) && !box_empty(h.b);
    return h;
  endfunction

  // Edges of an origin and a signed extent; a negative extent swaps them.
  function automatic mbox_t make_box(crd_t x, crd_t y, crd_t w, crd_t h);
    mbox_t m;
    logic signed [MW-1:0] x2;
    logic signed [MW-1:0] y2;
    x2 = MW'(x) + MW'(w);
    y2 = MW'(y) + MW'(h);
    m.l = w[CB-1] ? x2 : MW'(x);
    m.r = w[CB-1] ? MW'(x) : x2;
    m.t = h[CB-1] ? y2 : MW'(y);
    m.b = h[CB-1] ? MW'(y) : y2;
    return m;
  endfunction

endpackage

/* sv/blit_visible_rectangle_clipper.sv */
// Channel   Ports                        Transfer
// request   start, busy, req             edge with start high and busy low
// result    done, result                 every cycle with done high
// config    wr_en, wr_index, wr_data     every edge with wr_en high
//
// A request can be taken in every cycle; busy stays low.
// The result is computed through the two
// mapping units in series, each a multiply and a nine-stage divider.
// Synchronous reset clears the configuration registers and the pipeline valid bits.
// The result is shown for one cycle and cannot be held off.
module blit_visible_rectangle_clipper import bvrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       req,
  output logic       done,
  output res_t       result,
  input  logic       wr_en,
  input  logic [2:0] wr_index,
  input  logic [CB-1:0] wr_data
);

  crd_t          clip_l, clip_t, clip_r, clip_b;
  logic [EW-1:0] ext_w, ext_h;

  logic  v1, v2, v3, v4, vx, vy;
  req_t  rq1, rq2, rq3, rq4;
  mbox_t rd2, rs2;
  logic  okd3, oks3, eq3;
  box_t  dv3, sv3;
  logic  okd4, oks4, eq4;
  box_t  dv4, sv4;
  mbox_t shb4;

  side1_t s4, s1o;
  side2_t sx, s2o;
  logic   m1v, m2v;
  mbox_t  m1, m2;
  logic [$bits(side1_t)-1:0] s1o_bits;
  logic [$bits(side2_t)-1:0] s2o_bits;

  res_t res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_l <= '0;
      clip_t <= '0;
      clip_r <= '0;
      clip_b <= '0;
      ext_w  <= '0;
      ext_h  <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_CLIP_LEFT:   clip_l <= wr_data;
        REG_CLIP_TOP:    clip_t <= wr_data;
        REG_CLIP_RIGHT:  clip_r <= wr_data;
        REG_CLIP_BOTTOM: clip_b <= wr_data;
        REG_EXT_WIDTH:   ext_w  <= wr_data[EW-1:0];
        REG_EXT_HEIGHT:  ext_h  <= wr_data[EW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      vx   <= 1'b0;
      vy   <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      vx   <= m1v;
      vy   <= m2v;
    end
  end

  always_ff @(posedge clk) begin
    mbox_t clipm;
    mbox_t extm;
    hit_t  hd;
    hit_t  hs;
    rq1 <= req;

    rd2 <= make_box(rq1.dst_x, rq1.dst_y, rq1.dst_width, rq1.dst_height);
    rs2 <= make_box(rq1.src_x, rq1.src_y, rq1.src_width, rq1.src_height);
    rq2 <= rq1;

    clipm.l = MW'(clip_l);
    clipm.t = MW'(clip_t);
    clipm.r = MW'(clip_r);
    clipm.b = MW'(clip_b);
    extm.l  = '0;
    extm.t  = '0;
    extm.r  = MW'(ext_w);
    extm.b  = MW'(ext_h);
    hd = box_and(rd2, clipm);
    hs = box_and(rs2, extm);
    dv3  <= narrow(hd.b);
    sv3  <= narrow(hs.b);
    okd3 <= hd.ok;
    oks3 <= hs.ok;
    eq3  <= (rq2.src_width == rq2.dst_width) && (rq2.src_height == rq2.dst_height);
    rq3  <= rq2;

    // Without stretching the source moves into destination space by the
    // difference of the origins.
    shb4.l <= MW'(sv3.l) + MW'(rq3.dst_x) - MW'(rq3.src_x);
    shb4.r <= MW'(sv3.r) + MW'(rq3.dst_x) - MW'(rq3.src_x);
    shb4.t <= MW'(sv3.t) + MW'(rq3.dst_y) - MW'(rq3.src_y);
    shb4.b <= MW'(sv3.b) + MW'(rq3.dst_y) - MW'(rq3.src_y);
    dv4  <= dv3;
    sv4  <= sv3;
    okd4 <= okd3;
    oks4 <= oks3;
    eq4  <= eq3;
    rq4  <= rq3;
  end

  always_comb begin
    s4.rq  = rq4;
    s4.okd = okd4;
    s4.oks = oks4;
    s4.eq  = eq4;
    s4.dv  = dv4;
    s4.sv  = sv4;
    s4.shb = shb4;
  end

  bvrc_map #(
    .SIDE_W($bits(side1_t))
  ) u_map_dst (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v4),
    .a        (sv4),
    .aox      (rq4.src_x),
    .aoy      (rq4.src_y),
    .bx       (rq4.dst_x),
    .by       (rq4.dst_y),
    .num_x    (rq4.dst_width),
    .num_y    (rq4.dst_height),
    .den_x    (rq4.src_width),
    .den_y    (rq4.src_height),
    .side_in  (s4),
    .out_valid(m1v),
    .m        (m1),
    .side_out (s1o_bits)
  );

  assign s1o = side1_t'(s1o_bits);

  always_ff @(posedge clk) begin
    hit_t h1;
    hit_t he;
    h1 = box_and(m1, widen(s1o.dv));
    he = box_and(s1o.shb, widen(s1o.dv));
    sx.rq      <= s1o.rq;
    sx.okd     <= s1o.okd;
    sx.oks     <= s1o.oks;
    sx.eq      <= s1o.eq;
    sx.ok_eq   <= he.ok;
    sx.ok3     <= h1.ok;
    sx.req_box <= narrow(he.b);
    // A pattern-only request keeps the clipped destination as it is.
    sx.dv2     <= s1o.rq.has_source ? narrow(h1.b) : s1o.dv;
    sx.sv      <= s1o.sv;
  end

  bvrc_map #(
    .SIDE_W($bits(side2_t))
  ) u_map_src (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vx),
    .a        (sx.dv2),
    .aox      (sx.rq.dst_x),
    .aoy      (sx.rq.dst_y),
    .bx       (sx.rq.src_x),
    .by       (sx.rq.src_y),
    .num_x    (sx.rq.src_width),
    .num_y    (sx.rq.src_height),
    .den_x    (sx.rq.dst_width),
    .den_y    (sx.rq.dst_height),
    .side_in  (sx),
    .out_valid(m2v),
    .m        (m2),
    .side_out (s2o_bits)
  );

  assign s2o = side2_t'(s2o_bits);

  always_ff @(posedge clk) begin
    hit_t  h2;
    box_t  sve;
    box_t  dvo;
    box_t  svo;
    logic  vis;
    h2 = box_and(m2, widen(s2o.sv));
    sve.l = s2o.req_box.l + s2o.rq.src_x - s2o.rq.dst_x;
    sve.r = s2o.req_box.r + s2o.rq.src_x - s2o.rq.dst_x;
    sve.t = s2o.req_box.t + s2o.rq.src_y - s2o.rq.dst_y;
    sve.b = s2o.req_box.b + s2o.rq.src_y - s2o.rq.dst_y;
    dvo = '0;
    svo = '0;
    vis = 1'b0;
    if (s2o.okd) begin
      if (!s2o.rq.has_source) begin
        vis = 1'b1;
        dvo = s2o.dv2;
      end else if (s2o.oks) begin
        if (s2o.eq) begin
          if (s2o.ok_eq) begin
            vis = 1'b1;
            dvo = s2o.req_box;
            svo = sve;
          end
        end else if (s2o.ok3 && h2.ok) begin
          vis = 1'b1;
          dvo = s2o.dv2;
          svo = narrow(h2.b);
        end
      end
    end
    res.visible    <= vis;
    res.src_left   <= svo.l;
    res.src_top    <= svo.t;
    res.src_right  <= svo.r;
    res.src_bottom <= svo.b;
    res.dst_left   <= dvo.l;
    res.dst_top    <= dvo.t;
    res.dst_right  <= dvo.r;
    res.dst_bottom <= dvo.b;
  end

  assign done   = vy;
  assign result = res;

endmodule

/* sv/bvrc_map.sv */
module bvrc_map import bvrc_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  box_t              a,
  input  crd_t              aox,
  input  crd_t              aoy,
  input  crd_t              bx,
  input  crd_t              by,
  input  crd_t              num_x,
  input  crd_t              num_y,
  input  crd_t              den_x,
  input  crd_t              den_y,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output mbox_t             m,
  output logic [SIDE_W-1:0] side_out
);

  // Lanes in the order left, top, right, bottom; even lanes are x.
  crd_t ac [4];
  assign ac[0] = a.l;
  assign ac[1] = a.t;
  assign ac[2] = a.r;
  assign ac[3] = a.b;

  // Product stage.
  logic                 va;
  logic signed [PW-1:0] pa [4];
  crd_t                 pd_x, pd_y, po_x, po_y;
  logic [SIDE_W-1:0]    sa;

  // Divider stages; stage 0 holds the magnitudes.
  logic [NST:0]         vdiv;
  logic [QPW-1:0]       dq [NST+1][4];
  logic [CB-1:0]        dr [NST+1][4];
  logic [CB-1:0]        dd [NST+1][4];
  logic                 dn [NST+1][4];
  logic                 dz [NST+1][4];
  crd_t                 dox [NST+1];
  crd_t                 doy [NST+1];
  logic [SIDE_W-1:0]    dsd [NST+1];

  logic [QPW-1:0]       nq [NST][4];
  logic [CB-1:0]        nr [NST][4];

  // Scaled edges.
  logic                 vc;
  logic signed [MW-1:0] cv [4];
  logic [SIDE_W-1:0]    sc;

  logic                 vd;
  mbox_t                md;
  logic [SIDE_W-1:0]    sdd;

  always_comb begin
    logic [QPW-1:0] q;
    logic [CB:0]    t;
    logic [CB-1:0]  rr;
    for (int s = 0; s < NST; s++) begin
      for (int e = 0; e < 4; e++) begin
        q  = dq[s][e];
        rr = dr[s][e];
        for (int j = 0; j < BPS; j++) begin
          t = {rr, q[QPW-1]};
          q = {q[QPW-2:0], 1'b0};
          if (t >= {1'b0, dd[s][e]}) begin
            t    = t - {1'b0, dd[s][e]};
            q[0] = 1'b1;
          end
          rr = t[CB-1:0];
        end
        nq[s][e] = q;
        nr[s][e] = rr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va   <= 1'b0;
      vdiv <= '0;
      vc   <= 1'b0;
      vd   <= 1'b0;
    end else begin
      va   <= in_valid;
      vdiv <= {vdiv[NST-1:0], va};
      vc   <= vdiv[NST];
      vd   <= vc;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [CB:0]    diff;
    logic signed [PW-1:0]  p;
    crd_t                  dv;
    logic signed [QPW:0]   qs;
    logic signed [MW-1:0]  lo;
    logic signed [MW-1:0]  hi;
    for (int e = 0; e < 4; e++) begin
      diff  = (e % 2 == 0) ? ((CB+1)'(ac[e]) - (CB+1)'(aox))
                           : ((CB+1)'(ac[e]) - (CB+1)'(aoy));
      pa[e] <= (e % 2 == 0) ? PW'(diff * num_x) : PW'(diff * num_y);
    end
    pd_x <= den_x;
    pd_y <= den_y;
    po_x <= bx;
    po_y <= by;
    sa   <= side_in;

    for (int e = 0; e < 4; e++) begin
      p  = pa[e];
      dv = (e % 2 == 0) ? pd_x : pd_y;
      dq[0][e] <= QPW'(p[PW-1] ? -p : p);
      dr[0][e] <= '0;
      dd[0][e] <= dv[CB-1] ? CB'(-dv) : CB'(dv);
      dn[0][e] <= p[PW-1] ^ dv[CB-1];
      dz[0][e] <= (dv == '0);
    end
    dox[0] <= po_x;
    doy[0] <= po_y;
    dsd[0] <= sa;

    for (int s = 0; s < NST; s++) begin
      for (int e = 0; e < 4; e++) begin
        dq[s+1][e] <= nq[s][e];
        dr[s+1][e] <= nr[s][e];
        dd[s+1][e] <= dd[s][e];
        dn[s+1][e] <= dn[s][e];
        dz[s+1][e] <= dz[s][e];
      end
      dox[s+1] <= dox[s];
      doy[s+1] <= doy[s];
      dsd[s+1] <= dsd[s];
    end

    // Division truncates toward zero, so the sign goes on the magnitude.
    for (int e = 0; e < 4; e++) begin
      qs = dn[NST][e] ? -(QPW+1)'(dq[NST][e]) : (QPW+1)'(dq[NST][e]);
      if (dz[NST][e]) begin
        cv[e] <= (e % 2 == 0) ? MW'(dox[NST]) : MW'(doy[NST]);
      end else begin
        cv[e] <= (e % 2 == 0) ? MW'(dox[NST]) + MW'(qs) : MW'(doy[NST]) + MW'(qs);
      end
    end
    sc <= dsd[NST];

    lo = (cv[0] > cv[2]) ? cv[2] : cv[0];
    hi = (cv[0] > cv[2]) ? cv[0] : cv[2];
    md.l <= lo - MW'(1);
    md.r <= hi + MW'(1);
    lo = (cv[1] > cv[3]) ? cv[3] : cv[1];
    hi = (cv[1] > cv[3]) ? cv[1] : cv[3];
    md.t <= lo - MW'(1);
    md.b <= hi + MW'(1);
    sdd  <= sc;
  end

  assign out_valid = vd;
  assign m         = md;
  assign side_out  = sdd;

endmodule

/* test/blit_visible_rectangle_clipper_tb.sv */
module blit_visible_rectangle_clipper_tb;
  import bvrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    longint l, t, r, b;
  } rect_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  req_t req = '0;
  logic done;
  res_t result;
  logic wr_en = 0;
  logic [2:0] wr_index = '0;
  logic [CB-1:0] wr_data = '0;

  blit_visible_rectangle_clipper dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always #5 clk = ~clk;

  longint clip_left, clip_top, clip_right, clip_bottom, ext_width, ext_height;
  req_t   pending_blits[$];
  res_t   expected_clips[$];
  int     errors = 0;
  int     accepted = 0;
  int     results_seen = 0;
  int     visible_seen = 0;
  int     stall_cycles = 0;
  bit     calm = 0;
  bit     timed_out = 0;

  function automatic bit rect_empty(rect_t a);
    return a.l >= a.r || a.t >= a.b;
  endfunction

  function automatic bit rect_and(rect_t a, rect_t b, output rect_t o);
    rect_t x;
    if (rect_empty(a) || rect_empty(b)) return 0;
    x.l = a.l > b.l ? a.l : b.l;
    x.t = a.t > b.t ? a.t : b.t;
    x.r = a.r < b.r ? a.r : b.r;
    x.b = a.b < b.b ? a.b : b.b;
    if (rect_empty(x)) return 0;
    o = x;
    return 1;
  endfunction

  function automatic rect_t span_rect(longint x, longint y, longint w, longint h);
    rect_t a;
    a = '{x, y, x + w, y + h};
    if (w < 0) a = '{a.r, a.t, a.l, a.b};
    if (h < 0) a = '{a.l, a.b, a.r, a.t};
    return a;
  endfunction

  // Division truncates toward zero, as SystemVerilog's does for signed operands.
  function automatic longint rescale(longint org, longint d, longint num, longint den);
    if (den == 0) return org;
    return org + (d * num) / den;
  endfunction

  function automatic rect_t project_rect(rect_t a, longint ax, longint ay, longint bx,
                                         longint by, longint aw, longint ah,
                                         longint bw, longint bh);
    rect_t m;
    longint s;
    m.l = rescale(bx, a.l - ax, bw, aw);
    m.t = rescale(by, a.t - ay, bh, ah);
    m.r = rescale(bx, a.r - ax, bw, aw);
    m.b = rescale(by, a.b - ay, bh, ah);
    if (m.l > m.r) begin s = m.l; m.l = m.r; m.r = s; end
    if (m.t > m.b) begin s = m.t; m.t = m.b; m.b = s; end
    m.l--; m.t--; m.r++; m.b++;
    return m;
  endfunction

  function automatic res_t clip_blit(req_t q);
    longint dx, dy, dw, dh, sx, sy, sw, sh;
    rect_t dv, sv, r, m, clip, ext;
    bit ok;
    res_t o;
    dx = q.dst_x; dy = q.dst_y; dw = q.dst_width; dh = q.dst_height;
    sx = q.src_x; sy = q.src_y; sw = q.src_width; sh = q.src_height;
    dv = '{0, 0, 0, 0};
    sv = '{0, 0, 0, 0};
    clip = '{clip_left, clip_top, clip_right, clip_bottom};
    ok = rect_and(span_rect(dx, dy, dw, dh), clip, dv);
    if (ok && q.has_source) begin
      ext = '{0, 0, ext_width, ext_height};
      ok = rect_and(span_rect(sx, sy, sw, sh), ext, sv);
      if (ok) begin
        if (sw == dw && sh == dh) begin
          m = '{sv.l + dx - sx, sv.t + dy - sy, sv.r + dx - sx, sv.b + dy - sy};
          ok = rect_and(m, dv, r);
          if (ok) begin
            dv = r;
            sv = '{r.l + sx - dx, r.t + sy - dy, r.r + sx - dx, r.b + sy - dy};
          end
        end else begin
          m = project_rect(sv, sx, sy, dx, dy, sw, sh, dw, dh);
          ok = rect_and(m, dv, dv);
          if (ok) begin
            m = project_rect(dv, dx, dy, sx, sy, dw, dh, sw, sh);
            ok = rect_and(m, sv, sv);
          end
        end
      end
    end
    if (!ok) begin
      dv = '{0, 0, 0, 0};
      sv = '{0, 0, 0, 0};
    end else if (!q.has_source) begin
      sv = '{0, 0, 0, 0};
    end
    o.visible = ok;
    o.src_left = sv.l[CB-1:0];   o.src_top = sv.t[CB-1:0];
    o.src_right = sv.r[CB-1:0];  o.src_bottom = sv.b[CB-1:0];
    o.dst_left = dv.l[CB-1:0];   o.dst_top = dv.t[CB-1:0];
    o.dst_right = dv.r[CB-1:0];  o.dst_bottom = dv.b[CB-1:0];
    return o;
  endfunction

  // Driver: start stays high across back-to-back transfers.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_clips.push_back(clip_blit(req));
        accepted++;
      end
      if ((!start || !busy) && pending_blits.size() > 0 &&
          (calm || $urandom_range(99) >= 8)) begin
        start <= 1;
        req <= pending_blits.pop_front();
      end else if (!start || !busy) begin
        start <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (result.visible) visible_seen++;
      if (expected_clips.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        errors++;
      end else begin
        res_t e;
        e = expected_clips.pop_front();
        if (e !== result) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, result);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 2000) begin
      timed_out = 1;
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, longint v);
    @(posedge clk);
    wr_en <= 1;
    wr_index <= idx;
    wr_data <= v[CB-1:0];
    case (idx)
      REG_CLIP_LEFT:   clip_left = longint'(crd_t'(v[CB-1:0]));
      REG_CLIP_TOP:    clip_top = longint'(crd_t'(v[CB-1:0]));
      REG_CLIP_RIGHT:  clip_right = longint'(crd_t'(v[CB-1:0]));
      REG_CLIP_BOTTOM: clip_bottom = longint'(crd_t'(v[CB-1:0]));
      REG_EXT_WIDTH:   ext_width = v & 16'h7fff;
      REG_EXT_HEIGHT:  ext_height = v & 16'h7fff;
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 0;
  endtask

  task automatic set_window(longint l, longint t, longint r, longint b,
                            longint w, longint h);
    write_reg(REG_CLIP_LEFT, l);
    write_reg(REG_CLIP_TOP, t);
    write_reg(REG_CLIP_RIGHT, r);
    write_reg(REG_CLIP_BOTTOM, b);
    write_reg(REG_EXT_WIDTH, w);
    write_reg(REG_EXT_HEIGHT, h);
  endtask

  task automatic drain();
    while (pending_blits.size() > 0 || start || expected_clips.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic crd_t near_coord(int spread);
    return crd_t'($urandom_range(2 * spread) - spread);
  endfunction

  function automatic req_t random_blit(bit wild);
    req_t q;
    if (wild) begin
      q = req_t'({$urandom, $urandom, $urandom, $urandom, 1'($urandom)});
    end else begin
      q.dst_x = near_coord(300);  q.dst_y = near_coord(300);
      q.dst_width = near_coord(200);  q.dst_height = near_coord(200);
      q.src_x = near_coord(300);  q.src_y = near_coord(300);
      if ($urandom_range(2) == 0) begin
        q.src_width = q.dst_width;  q.src_height = q.dst_height;
      end else begin
        q.src_width = near_coord(200);  q.src_height = near_coord(200);
      end
      q.has_source = $urandom_range(9) != 0;
    end
    return q;
  endfunction

  initial begin
    req_t q;
    clip_left = 0; clip_top = 0; clip_right = 0; clip_bottom = 0;
    ext_width = 0; ext_height = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    // Reset values: everything clipped away.
    pending_blits.push_back(req_t'({16'sd0, 16'sd0, 16'sd10, 16'sd10,
                                    16'sd0, 16'sd0, 16'sd10, 16'sd10, 1'b1}));
    drain();
    set_window(-100, -80, 400, 300, 256, 192);
    // Plain copy, mirrored, stretched, no source, zero extent, off screen.
    pending_blits.push_back(req_t'({16'sd10, 16'sd10, 16'sd50, 16'sd40,
                                    16'sd5, 16'sd5, 16'sd50, 16'sd40, 1'b1}));
    pending_blits.push_back(req_t'({16'sd100, 16'sd100, -16'sd50, -16'sd40,
                                    16'sd60, 16'sd60, -16'sd50, -16'sd40, 1'b1}));
    pending_blits.push_back(req_t'({16'sd0, 16'sd0, 16'sd300, 16'sd200,
                                    16'sd0, 16'sd0, 16'sd100, -16'sd50, 1'b1}));
    pending_blits.push_back(req_t'({-16'sd150, -16'sd90, 16'sd100, 16'sd70,
                                    16'sd200, 16'sd150, 16'sd100, 16'sd100, 1'b1}));
    pending_blits.push_back(req_t'({16'sd20, 16'sd20, 16'sd30, 16'sd30,
                                    16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0}));
    pending_blits.push_back(req_t'({16'sd20, 16'sd20, 16'sd0, 16'sd30,
                                    16'sd0, 16'sd0, 16'sd5, 16'sd5, 1'b1}));
    pending_blits.push_back(req_t'({16'sd20, 16'sd20, 16'sd30, 16'sd30,
                                    16'sd300, 16'sd0, 16'sd5, 16'sd5, 1'b1}));
    pending_blits.push_back(req_t'({16'sd600, 16'sd20, 16'sd30, 16'sd30,
                                    16'sd0, 16'sd0, 16'sd5, 16'sd5, 1'b1}));
    pending_blits.push_back(req_t'({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                    16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1}));
    pending_blits.push_back(req_t'({16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                    16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1}));
    pending_blits.push_back(req_t'({16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                                    16'h0000, 16'h0000, 16'h7fff, 16'h8001, 1'b1}));
    pending_blits.push_back(req_t'({16'sd0, 16'sd0, 16'sd1, 16'sd1,
                                    16'sd0, 16'sd0, 16'h7fff, 16'h7fff, 1'b1}));
    drain();
    // Extreme window, then a few mid-sized ones.
    set_window(-32768, -32768, 32767, 32767, 32767, 32767);
    calm = 1;
    for (int i = 0; i < 150; i++) pending_blits.push_back(random_blit($urandom_range(1)));
    drain();
    calm = 0;
    for (int phase = 0; phase < 4; phase++) begin
      set_window(near_coord(200), near_coord(200), near_coord(400), near_coord(400),
                 $urandom_range(400), $urandom_range(400));
      if (phase == 3) write_reg(3'd7, 16'h1234);
      for (int i = 0; i < 220; i++) pending_blits.push_back(random_blit($urandom_range(9) == 0));
      drain();
    end
    $display("Ran %0d blit requests over several clip windows; %0d results, %0d visible.",
             accepted, results_seen, visible_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
